// ----- rtl/igfr_pkg.sv -----
// Shared types and constants of the idle gap frame receiver.
package igfr_pkg;

   localparam int FRAME_LEN = 9;
   localparam logic [7:0] HEAD_MARK = 8'hDF;
   localparam logic [7:0] TAIL_MARK = 8'hFD;
   localparam logic [7:0] IDLE_LIMIT_RESET = 8'd10;
   localparam logic [3:0] LAST_INDEX = 4'(FRAME_LEN - 1);

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] index_type;
   typedef byte_type [FRAME_LEN-1:0] frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } frame_push_type;

endpackage

// ----- rtl/igfr_front.sv -----
// Front end: byte capture, idle timer and frame check at timeout.
module igfr_front #(
   parameter int BUF_DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  igfr_pkg::op_type         operation,
   input  igfr_pkg::byte_type       rx_byte,
   input  logic                     csr_wr_en,
   input  igfr_pkg::byte_type       csr_wr_data,
   output igfr_pkg::frame_push_type frame_push
);
   import igfr_pkg::*;

   localparam int PW = $clog2(BUF_DEPTH + 1);

   byte_type       store_ff [FRAME_LEN];
   byte_type       store_in [FRAME_LEN];
   logic [PW-1:0]  pos_ff, pos_in;
   byte_type       idle_ff, idle_in;
   logic           run_ff, run_in;
   byte_type       limit_ff;
   logic [9:0]     sum;
   logic           valid_frame;
   frame_type      snap;

   always_comb begin
      sum = 10'(store_ff[4]) + 10'(store_ff[5]) + 10'(store_ff[6]);
      valid_frame = (store_ff[0] == HEAD_MARK) && (store_ff[1] == HEAD_MARK) &&
                    (store_ff[8] == TAIL_MARK) && (sum == 10'(store_ff[7]));
      for (int k = 0; k < FRAME_LEN; k++) begin
         snap[k] = store_ff[k];
      end
   end

   always_comb begin
      store_in = store_ff;
      pos_in = pos_ff;
      idle_in = idle_ff;
      run_in = run_ff;
      frame_push.valid = 1'b0;
      frame_push.frame = snap;
      if (accept) begin
         if (operation == OP_BYTE) begin
            idle_in = '0;
            run_in = 1'b1;
            if (pos_ff >= PW'(BUF_DEPTH)) begin
               // wrap: buffer full, restart at entry 0
               store_in[0] = rx_byte;
               pos_in = PW'(1);
            end else begin
               // only the first frame-length entries are ever read back
               for (int k = 0; k < FRAME_LEN; k++) begin
                  if (pos_ff == PW'(k)) begin
                     store_in[k] = rx_byte;
                  end
               end
               pos_in = pos_ff + PW'(1);
            end
         end else if (run_ff) begin
            if (idle_ff < limit_ff) begin
               idle_in = idle_ff + 8'd1;
            end else begin
               if (valid_frame) begin
                  frame_push.valid = 1'b1;
                  for (int k = 0; k < FRAME_LEN; k++) begin
                     store_in[k] = '0;
                  end
               end
               idle_in = '0;
               pos_in = '0;
               run_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRAME_LEN; k++) begin
            store_ff[k] <= '0;
         end
         pos_ff <= '0;
         idle_ff <= '0;
         run_ff <= 1'b1;
         limit_ff <= IDLE_LIMIT_RESET;
      end else begin
         store_ff <= store_in;
         pos_ff <= pos_in;
         idle_ff <= idle_in;
         run_ff <= run_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ----- rtl/igfr_frame_fifo.sv -----
// Two-entry queue of checked frames between front and back end.
module igfr_frame_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  igfr_pkg::frame_push_type wr,
   input  logic                     rd_en,
   output igfr_pkg::frame_type      rd_frame,
   output logic                     empty,
   output logic                     full
);
   import igfr_pkg::*;

   frame_type  mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_wr, do_rd;

   assign empty = (count_ff == 2'd0);
   assign full = (count_ff == 2'd2);
   assign do_wr = wr.valid && !full;
   assign do_rd = rd_en && !empty;
   assign rd_frame = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_rd) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_wr) - 2'(do_rd);
      end
   end

endmodule

// ----- rtl/igfr_back.sv -----
// Back end: serializes one queued frame into nine result words.
module igfr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  igfr_pkg::frame_type q_frame,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output igfr_pkg::byte_type  rsp_frame_byte,
   output igfr_pkg::index_type rsp_byte_index,
   output logic                rsp_last
);
   import igfr_pkg::*;

   byte_type  frame_ff [FRAME_LEN];
   index_type idx_ff, idx_in;
   logic      busy_ff, busy_in;
   logic      load;

   assign load = !busy_ff && !q_empty;
   assign q_pop = load;
   assign rsp_empty = !busy_ff;
   assign rsp_frame_byte = frame_ff[idx_ff];
   assign rsp_byte_index = idx_ff;
   assign rsp_last = (idx_ff == LAST_INDEX);

   always_comb begin
      idx_in = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         idx_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff && rsp_pop) begin
         if (idx_ff == LAST_INDEX) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < FRAME_LEN; k++) begin
            frame_ff[k] <= q_frame[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- rtl/idle_gap_frame_receiver.sv -----
// Top level of the idle gap frame receiver.
// Usage:
//   Input queue (req_push/full): each word is a received byte (operation 0)
//   or an idle timer tick (operation 1). Bytes fill a buffer of BUF_DEPTH
//   positions; the tick that follows idle_limit counted ticks checks the
//   frame in entries 0..8 and, if it is valid, queues it for output.
//   Result queue (rsp_empty/rsp_pop): a valid frame comes out as nine words,
//   byte_index 0..8, last set on the ninth.
//   csr_wr_en/csr_wr_data write idle_limit; write only while idle.
//   The front end takes one word per cycle while full is low. A valid
//   frame is written into the queue, then loaded into the back end, and
//   each word goes out in the cycle it is popped; after the last word
//   the back end goes idle before it loads the next frame.
//   A two-frame queue sits between front and back; full rises only while it
//   holds two frames that the receiver has not started to pop.
//   Reset clears the buffer, sets idle_limit to 10 and arms the idle timer.
module idle_gap_frame_receiver #(
   parameter int BUF_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       full,
   input  logic       req_operation,
   input  logic [7:0] req_rx_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_frame_byte,
   output logic [3:0] rsp_byte_index,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import igfr_pkg::*;

   frame_push_type push_bus;
   frame_type      q_frame;
   logic           q_empty, q_full, q_pop;
   logic           accept;

   assign full = q_full;
   assign accept = req_push && !q_full;

   igfr_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (op_type'(req_operation)),
      .rx_byte    (req_rx_byte),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .frame_push (push_bus)
   );

   igfr_frame_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (push_bus),
      .rd_en   (q_pop),
      .rd_frame(q_frame),
      .empty   (q_empty),
      .full    (q_full)
   );

   igfr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_frame       (q_frame),
      .q_pop         (q_pop),
      .rsp_pop       (pop),
      .rsp_empty     (empty),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last      (rsp_last)
   );

endmodule
